// ----- sv/double_ended_queue_core_macros.svh -----
// Assertion macros used by the checker file of the deque core.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define DQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ----- sv/dq_pkg.sv -----
package dq_pkg;

    // Command codes.
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] data_in;
    } dq_in_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic        is_empty;
        logic [4:0]  occupancy;
    } dq_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic load;
    } dq_ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } dq_dp_status_t;

endpackage

// ----- sv/double_ended_queue_core.sv -----
// Bounded double-ended queue of DEPTH words of DATA_WIDTH bits, kept as a ring in a
// single RAM. Each input item carries one command (push front, push back, pop front,
// pop back, peek front, peek back) and produces exactly one result item with the word
// read, a status (ok, empty, full), an empty flag and the occupancy after the command.
// A pop or peek on an empty queue and a push on a full queue report their status and
// change nothing; unused command codes return ok with no effect. The block works on
// one item at a time: an item is accepted in the idle cycle, the RAM write or read
// happens on that same edge, and the result is loaded into the output register
// from the load state once the output register is free; the load state is there for
// the registered read port of the ring RAM. The output register holds a finished
// result while the next item is accepted; if that result is still waiting when the
// new one is ready, the block holds the new one until the output frees up.
// Words pushed are cut to DATA_WIDTH bits, data_out shows the low 32 bits of the word
// and occupancy the low 5 bits of the count.
module double_ended_queue_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dq_pkg::dq_in_t  s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output dq_pkg::dq_out_t m_item
);

    localparam int AW = $clog2(DEPTH);

    // Controller and datapath talk only through these two structs.
    dq_pkg::dq_ctrl_cmd_t  ctrl_cmd;
    dq_pkg::dq_dp_status_t dp_status;

    // Ring RAM port signals.
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    // The controller sequences accept and result load.
    dq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status)
    );

    // The datapath holds the front index, the word count and the output register.
    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .ctrl_cmd    (ctrl_cmd),
        .dp_status   (dp_status),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Slot storage. Slots are read only after a push has written them, so the RAM
    // needs no clearing after reset.
    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ----- sv/dq_ram.sv -----
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/dq_ctrl.sv -----
module dq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output dq_pkg::dq_ctrl_cmd_t  ctrl_cmd,
    input  dq_pkg::dq_dp_status_t dp_status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } dq_state_t;

    dq_state_t state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        ctrl_cmd.exec = 1'b0;
        ctrl_cmd.load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                ctrl_cmd.exec = s_valid;
                if (s_valid) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                // The read word is ready now; wait only for a free output register.
                if (!dp_status.out_stall) begin
                    ctrl_cmd.load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/dq_datapath.sv -----
module dq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dq_pkg::dq_in_t           s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output dq_pkg::dq_out_t          m_item,
    input  dq_pkg::dq_ctrl_cmd_t     ctrl_cmd,
    output dq_pkg::dq_dp_status_t    dp_status,
    output logic                     ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
    output logic [DATA_WIDTH-1:0]    ram_wr_data,
    output logic                     ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]    ram_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rd_sel_reg, rd_sel_next;
    logic [1:0]    status_reg, status_next;
    logic          out_valid_reg, out_valid_next;
    dq_pkg::dq_out_t m_item_reg, m_item_next;

    logic [SW-1:0] sum_tail, sum_back;
    logic [AW-1:0] tail_idx, back_idx, front_dec, front_inc;
    logic          full, empty;
    logic [DATA_WIDTH+31:0] wr_wide, rd_wide;
    logic [CW+4:0]          occ_wide;

    // Ring positions: tail is the free slot behind the back word.
    always_comb begin
        sum_tail  = SW'(front_reg) + SW'(count_reg);
        tail_idx  = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
        sum_back  = sum_tail - SW'(1);
        back_idx  = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
        front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
        front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
        full      = (count_reg == CW'(DEPTH));
        empty     = (count_reg == '0);
        wr_wide   = (DATA_WIDTH + 32)'(s_item.data_in);
        rd_wide   = (DATA_WIDTH + 32)'(ram_rd_data);
        occ_wide  = (CW + 5)'(count_reg);
    end

    assign ram_wr_data = wr_wide[DATA_WIDTH-1:0];

    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        rd_sel_next = rd_sel_reg;
        status_next = status_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_idx;
        ram_rd_en   = 1'b0;
        ram_rd_addr = front_reg;
        if (ctrl_cmd.exec) begin
            rd_sel_next = 1'b0;
            status_next = dq_pkg::STAT_OK;
            if (s_item.cmd inside {dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK}) begin
                if (full) begin
                    status_next = dq_pkg::STAT_FULL;
                end
            end else if (s_item.cmd inside {[dq_pkg::CMD_POP_FRONT:dq_pkg::CMD_PEEK_BACK]}) begin
                if (empty) begin
                    status_next = dq_pkg::STAT_EMPTY;
                end
            end
            case (s_item.cmd)
                dq_pkg::CMD_PUSH_FRONT: begin
                    if (!full) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = front_dec;
                        front_next  = front_dec;
                        count_next  = count_reg + CW'(1);
                    end
                end
                dq_pkg::CMD_PUSH_BACK: begin
                    if (!full) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tail_idx;
                        count_next  = count_reg + CW'(1);
                    end
                end
                dq_pkg::CMD_POP_FRONT: begin
                    if (!empty) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = front_reg;
                        rd_sel_next = 1'b1;
                        front_next  = front_inc;
                        count_next  = count_reg - CW'(1);
                    end
                end
                dq_pkg::CMD_POP_BACK: begin
                    if (!empty) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = back_idx;
                        rd_sel_next = 1'b1;
                        count_next  = count_reg - CW'(1);
                    end
                end
                dq_pkg::CMD_PEEK_FRONT: begin
                    if (!empty) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = front_reg;
                        rd_sel_next = 1'b1;
                    end
                end
                dq_pkg::CMD_PEEK_BACK: begin
                    if (!empty) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = back_idx;
                        rd_sel_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_item_next    = m_item_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (ctrl_cmd.load) begin
            m_item_next.data_out  = rd_sel_reg ? rd_wide[31:0] : 32'd0;
            m_item_next.status    = status_reg;
            m_item_next.is_empty  = empty;
            m_item_next.occupancy = occ_wide[4:0];
            out_valid_next        = 1'b1;
        end
    end

    assign dp_status.out_stall = out_valid_reg && !m_ready;
    assign m_valid             = out_valid_reg;
    assign m_item              = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_sel_reg <= rd_sel_next;
        status_reg <= status_next;
        m_item_reg <= m_item_next;
    end

endmodule

// ----- sv/dq_checker.sv -----
`include "double_ended_queue_core_macros.svh"

module dq_checker #(
    parameter int DEPTH = 16
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input dq_pkg::dq_out_t m_item
);

    // A stalled result holds.
    `DQ_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item))

    // One item at a time: no accept right after an accept.
    `DQ_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

    // An empty status means nothing was read and the queue is empty.
    `DQ_ASSERT_IMPL(a_empty_status, m_valid && (m_item.status == dq_pkg::STAT_EMPTY),
                    m_item.is_empty && (m_item.data_out == 32'd0))

    // The empty flag agrees with the occupancy while the count fits in five bits.
    `DQ_ASSERT_IMPL(a_empty_flag, m_valid && (DEPTH < 32),
                    m_item.is_empty == (m_item.occupancy == 5'd0))

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
